// ----- src/olc_pkg.sv -----
package olc_pkg;

   // item kinds carried in tuser
   localparam logic ITEM_SENSOR = 1'b0;
   localparam logic ITEM_KEY    = 1'b1;

   // key codes
   localparam logic [2:0] KEY_MODE   = 3'd1;
   localparam logic [2:0] KEY_SELECT = 3'd2;
   localparam logic [2:0] KEY_TOGGLE = 3'd3;
   localparam logic [2:0] KEY_GEAR   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_LEAVE_DELAY = 2'd0;
   localparam logic [1:0] CSR_OFF_THR     = 2'd1;
   localparam logic [1:0] CSR_LOW_THR     = 2'd2;
   localparam logic [1:0] CSR_MID_THR     = 2'd3;

   localparam logic [31:0] LEAVE_DELAY_RST = 32'd30000;
   localparam logic [9:0]  OFF_THR_RST     = 10'd850;
   localparam logic [9:0]  LOW_THR_RST     = 10'd550;
   localparam logic [9:0]  MID_THR_RST     = 10'd250;

   typedef struct packed {
      logic [31:0] leave_delay_ms;
      logic [9:0]  off_threshold;
      logic [9:0]  low_gear_threshold;
      logic [9:0]  mid_gear_threshold;
   } olc_cfg_type;

   typedef struct packed {
      logic        mode;
      logic [2:0]  key_code;
      logic [9:0]  light_level;
      logic        presence_detected;
      logic [31:0] now_ms;
   } olc_item_type;

   typedef struct packed {
      logic [2:0] relay_mask;
      logic [2:0] on_mask;
      logic [1:0] gear_first;
      logic [1:0] gear_second;
      logic [1:0] gear_third;
      logic       manual_active;
      logic [1:0] selected_channel;
      logic       person_flag;
   } olc_rsp_type;

   function automatic logic [1:0] gear_for_level(input logic [9:0] level,
                                                 input olc_cfg_type cfg);
      logic [1:0] gear;
      if (level >= cfg.off_threshold) begin
         gear = 2'd0;
      end else if (level > cfg.low_gear_threshold) begin
         gear = 2'd1;
      end else if (level > cfg.mid_gear_threshold) begin
         gear = 2'd2;
      end else begin
         gear = 2'd3;
      end
      return gear;
   endfunction

endpackage

// ----- src/olc_cfg_regs.sv -----
module olc_cfg_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_addr,
   input  logic [31:0]          csr_wdata,
   output olc_pkg::olc_cfg_type cfg
);

   olc_pkg::olc_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leave_delay_ms     <= olc_pkg::LEAVE_DELAY_RST;
         cfg_ff.off_threshold      <= olc_pkg::OFF_THR_RST;
         cfg_ff.low_gear_threshold <= olc_pkg::LOW_THR_RST;
         cfg_ff.mid_gear_threshold <= olc_pkg::MID_THR_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            olc_pkg::CSR_LEAVE_DELAY: cfg_ff.leave_delay_ms     <= csr_wdata;
            olc_pkg::CSR_OFF_THR:     cfg_ff.off_threshold      <= csr_wdata[9:0];
            olc_pkg::CSR_LOW_THR:     cfg_ff.low_gear_threshold <= csr_wdata[9:0];
            olc_pkg::CSR_MID_THR:     cfg_ff.mid_gear_threshold <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/olc_state.sv -----
module olc_state #(
   parameter int CHANNELS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update_en,
   input  olc_pkg::olc_item_type item,
   input  olc_pkg::olc_cfg_type  cfg,
   output olc_pkg::olc_rsp_type  rsp_next
);

   localparam int SEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(CHANNELS - 1);

   logic                manual_ff, manual_in;
   logic [SEL_W-1:0]    sel_ff, sel_in;
   logic [CHANNELS-1:0] on_ff, on_in;
   logic [1:0]          gear_ff [CHANNELS];
   logic [1:0]          gear_in [CHANNELS];
   logic                person_ff, person_in;
   logic [31:0]         deadline_ff, deadline_in;

   logic [1:0]          level_gear;
   logic                cur_on;
   logic [1:0]          cur_gear;
   logic [1:0]          toggle_gear;
   logic [1:0]          step_gear;
   logic                run_auto;
   logic [31:0]         arm_deadline;
   logic [CHANNELS-1:0] gear_nz_in;
   logic [CHANNELS-1:0] gear_nz_ff;
   logic [2:0]          on_mask3;
   logic [2:0]          relay_mask3;
   logic [1:0]          gear3 [3];

   assign level_gear  = olc_pkg::gear_for_level(item.light_level, cfg);
   assign cur_on      = on_ff[sel_ff];
   assign cur_gear    = gear_ff[sel_ff];
   // switching on from gear 0 lands on gear 1, switching off clears the gear
   assign toggle_gear = cur_on ? 2'd0 : ((cur_gear == 2'd0) ? 2'd1 : cur_gear);
   assign step_gear   = cur_gear + 2'd1;

   always_comb begin
      manual_in    = manual_ff;
      sel_in       = sel_ff;
      on_in        = on_ff;
      gear_in      = gear_ff;
      person_in    = person_ff;
      deadline_in  = deadline_ff;
      run_auto     = 1'b0;

      if (item.mode == olc_pkg::ITEM_SENSOR) begin
         if (!manual_ff) begin
            run_auto = 1'b1;
         end else begin
            person_in = item.presence_detected;
         end
      end else if (item.key_code == olc_pkg::KEY_MODE) begin
         manual_in   = ~manual_ff;
         deadline_in = '0;
         run_auto    = manual_ff;
      end else if (manual_ff) begin
         case (item.key_code)
            olc_pkg::KEY_SELECT: begin
               sel_in = (sel_ff == LAST_SEL) ? '0 : sel_ff + 1'b1;
            end
            olc_pkg::KEY_TOGGLE: begin
               on_in[sel_ff]   = ~cur_on;
               gear_in[sel_ff] = toggle_gear;
            end
            olc_pkg::KEY_GEAR: begin
               on_in[sel_ff]   = (step_gear != 2'd0);
               gear_in[sel_ff] = step_gear;
            end
            default: ;
         endcase
      end

      // zero deadline means unarmed; arming wraps at 32 bits
      arm_deadline = (deadline_in == '0) ? item.now_ms + cfg.leave_delay_ms : deadline_in;

      if (run_auto) begin
         person_in = item.presence_detected;
         if (item.presence_detected) begin
            deadline_in = '0;
            for (int i = 0; i < CHANNELS; i++) begin
               gear_in[i] = level_gear;
            end
            on_in = {CHANNELS{level_gear != 2'd0}};
         end else begin
            deadline_in = arm_deadline;
            if (item.now_ms >= arm_deadline) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  gear_in[i] = 2'd0;
               end
               on_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         manual_ff   <= 1'b0;
         sel_ff      <= '0;
         on_ff       <= '0;
         person_ff   <= 1'b0;
         deadline_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            gear_ff[i] <= 2'd0;
         end
      end else if (update_en) begin
         manual_ff   <= manual_in;
         sel_ff      <= sel_in;
         on_ff       <= on_in;
         person_ff   <= person_in;
         deadline_ff <= deadline_in;
         gear_ff     <= gear_in;
      end
   end

   // result fields, channels past the third are dropped
   for (genvar i = 0; i < CHANNELS; i++) begin : g_nz
      assign gear_nz_in[i] = (gear_in[i] != 2'd0);
      assign gear_nz_ff[i] = (gear_ff[i] != 2'd0);
   end

   for (genvar i = 0; i < 3; i++) begin : g_out
      if (i < CHANNELS) begin : g_have
         assign on_mask3[i]    = on_in[i];
         assign relay_mask3[i] = on_in[i] & gear_nz_in[i];
         assign gear3[i]       = gear_in[i];
      end else begin : g_none
         assign on_mask3[i]    = 1'b0;
         assign relay_mask3[i] = 1'b0;
         assign gear3[i]       = 2'd0;
      end
   end

   if (SEL_W >= 2) begin : g_sel_wide
      assign rsp_next.selected_channel = sel_in[1:0];
   end else begin : g_sel_narrow
      assign rsp_next.selected_channel = {1'b0, sel_in};
   end

   assign rsp_next.relay_mask    = relay_mask3;
   assign rsp_next.on_mask       = on_mask3;
   assign rsp_next.gear_first    = gear3[0];
   assign rsp_next.gear_second   = gear3[1];
   assign rsp_next.gear_third    = gear3[2];
   assign rsp_next.manual_active = manual_in;
   assign rsp_next.person_flag   = person_in;

`ifndef SYNTHESIS
   a_manual_unarmed: assert property (@(posedge clock) disable iff (reset)
      manual_ff |-> (deadline_ff == '0))
      else $error("leave deadline armed in manual mode");

   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      sel_ff <= LAST_SEL)
      else $error("selected channel out of range");

   a_on_matches_gear: assert property (@(posedge clock) disable iff (reset)
      on_ff == gear_nz_ff)
      else $error("channel on flag disagrees with its gear");
`endif

endmodule

// ----- src/occupancy_light_controller_unit.sv -----
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: mode; tdata: key, level, presence, now
// rsp      out  rsp_tvalid/rsp_tready  tdata: masks, gears, mode, selection, presence
// csr      in   csr_we (no wait)       csr_addr: register index, csr_wdata: value
//
// One beat per cycle sustained while rsp is ready; a beat's result is on rsp once it
// has passed the input register, then the result register.
// The state update, the 32-bit deadline add and compare all sit between the two.
// Reset (synchronous, active high) restores auto mode, all channels off and
// the register defaults. A stalled rsp holds its beat and a full stall holds two;
// req takes a beat while the input register is empty or moving on.
module occupancy_light_controller_unit #(
   parameter int CHANNELS = 3
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] mode
   // [2:0] key_code, [12:3] light_level, [13] presence_detected,
   // [45:14] now_ms, [47:46] zero
   input  logic [47:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] relay_mask, [5:3] on_mask, [7:6] gear_first, [9:8] gear_second,
   // [11:10] gear_third, [12] manual_active, [14:13] selected_channel,
   // [15] person_flag
   output logic [15:0] rsp_tdata,

   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   olc_pkg::olc_cfg_type  cfg;
   olc_pkg::olc_item_type item_ff;
   olc_pkg::olc_rsp_type  rsp_next;
   olc_pkg::olc_rsp_type  rsp_ff;

   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_ready;
   logic advance;
   logic req_fire;

   // result register is free when empty or draining this cycle
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.mode              <= req_tuser[0];
         item_ff.key_code          <= req_tdata[2:0];
         item_ff.light_level       <= req_tdata[12:3];
         item_ff.presence_detected <= req_tdata[13];
         item_ff.now_ms            <= req_tdata[45:14];
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   olc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state advances exactly when the beat moves into the result register
   olc_state #(
      .CHANNELS (CHANNELS)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .update_en (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .rsp_next  (rsp_next)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {rsp_ff.person_flag, rsp_ff.selected_channel, rsp_ff.manual_active,
                        rsp_ff.gear_third, rsp_ff.gear_second, rsp_ff.gear_first,
                        rsp_ff.on_mask, rsp_ff.relay_mask};

`ifndef SYNTHESIS
   a_relay_is_on: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_ff.relay_mask == rsp_ff.on_mask))
      else $error("relay mask differs from on mask");

   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("taken beat not held in input register");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced beat missing from result register");
`endif

endmodule
